/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks that a build can compile out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMP(label, clk, rst_n, pre, post)
`define ASSERT_NXT(label, clk, rst_n, pre, post)

`endif

`endif

/* hw/rtl/sacl_pkg.sv */
// ---------------------------------------------------------------------------
// sacl_pkg
// geometry, types and helpers of the set-associative lru cache lookup
// ---------------------------------------------------------------------------
package sacl_pkg;

    localparam int ADDR_BITS    = 16;
    localparam int NUM_WAYS     = 4;
    localparam int NUM_SETS     = 4;

    localparam int ADDR_IN_BITS = 16;
    localparam int WAY_OUT_BITS = 2;
    localparam int CNT_BITS     = 32;
    localparam int COST_BITS    = 16;
    localparam int CFG_IDX_BITS = 2;

    // set count is a power of two: the set is the low address bits
    localparam int SET_BITS  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int TAG_BITS  = ADDR_BITS - SET_BITS;
    localparam int WAY_BITS  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int RANK_BITS = WAY_BITS;
    localparam int FILL_BITS = $clog2(NUM_WAYS + 1);

    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_HIT_COST  = cfg_idx_t'(0);
    localparam cfg_idx_t CFG_MISS_COST = cfg_idx_t'(1);

    typedef logic [TAG_BITS-1:0]  tag_t;
    typedef logic [RANK_BITS-1:0] rank_t;
    typedef logic [FILL_BITS-1:0] fill_t;
    typedef logic [WAY_BITS-1:0]  way_t;
    typedef logic [SET_BITS-1:0]  set_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [COST_BITS-1:0] cost_t;

    typedef logic [NUM_WAYS-1:0][TAG_BITS-1:0]  tag_row_t;
    typedef logic [NUM_WAYS-1:0][RANK_BITS-1:0] rank_row_t;

    typedef struct packed {
        logic hit;
        logic fill;
        way_t way;
    } lookup_t;

    function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
        logic [CNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_BITS] ? '1 : s[CNT_BITS-1:0];
    endfunction

endpackage

/* hw/rtl/sacl_if.sv */
// ---------------------------------------------------------------------------
// sacl channel interfaces
// request, response and configuration channels with valid/ready handshake
// ---------------------------------------------------------------------------
interface sacl_req_if import sacl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ADDR_IN_BITS-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface sacl_rsp_if import sacl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic [WAY_OUT_BITS-1:0] way_used;
    cnt_t                    hits_so_far;
    cnt_t                    misses_so_far;
    cnt_t                    latency_total;

    modport source (output valid, output hit, output way_used, output hits_so_far,
                    output misses_so_far, output latency_total, input ready);
    modport sink   (input valid, input hit, input way_used, input hits_so_far,
                    input misses_so_far, input latency_total, output ready);
endinterface

interface sacl_cfg_if import sacl_pkg::*; ();
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    cost_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/sacl_way_select.sv */
// ---------------------------------------------------------------------------
// sacl_way_select
// tag match, victim choice and lru rank update for one set
// ---------------------------------------------------------------------------
module sacl_way_select import sacl_pkg::*;
(
    input  tag_row_t  tags,
    input  rank_row_t ranks,
    input  fill_t     filled,
    input  tag_t      tag,
    output lookup_t   lk,
    output rank_row_t ranks_next,
    output fill_t     filled_next
);

    always_comb
    begin
        fill_t n;
        fill_t n_after;
        rank_t old_rank;
        way_t  victim;
        way_t  way;
        logic  found;

        n = (filled > FILL_BITS'(NUM_WAYS)) ? FILL_BITS'(NUM_WAYS) : filled;

        // lowest filled way with a matching tag
        found = 1'b0;
        way   = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (!found && (FILL_BITS'(w) < n) && (tags[w] == tag))
            begin
                found = 1'b1;
                way   = WAY_BITS'(w);
            end
        end

        // oldest way, lowest index on a tie
        victim = '0;
        for (int w = 1; w < NUM_WAYS; w++)
        begin
            if (ranks[w] > ranks[victim])
                victim = WAY_BITS'(w);
        end

        lk.hit  = found;
        lk.fill = 1'b0;
        if (found)
        begin
            old_rank = ranks[way];
            n_after  = filled;
        end
        else if (n < FILL_BITS'(NUM_WAYS))
        begin
            way      = WAY_BITS'(n);
            old_rank = RANK_BITS'(n);
            n_after  = n + 1'b1;
            lk.fill  = 1'b1;
        end
        else
        begin
            way      = victim;
            old_rank = ranks[victim];
            n_after  = filled;
        end
        lk.way = way;

        // ways newer than the touched one age by one
        ranks_next = ranks;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if ((FILL_BITS'(i) < n_after) && (WAY_BITS'(i) != way) && (ranks[i] < old_rank))
                ranks_next[i] = RANK_BITS'(ranks[i] + 1'b1);
        end
        ranks_next[way] = '0;
        filled_next     = n_after;
    end

endmodule

/* hw/rtl/set_assoc_lru_cache_lookup.sv */
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_lookup
// 4-way set-associative tag lookup with lru replacement and running totals
// ---------------------------------------------------------------------------
//  channel  dir  payload                                          handshake
//  req      in   address                                          valid/ready
//  rsp      out  hit, way_used, hits/misses_so_far, latency_total  valid/ready
//  cfg      in   index, data (hit_cost, miss_cost)                valid/ready
//
//  one transaction per cycle sustained while rsp is ready; a request passes the
//  input register, then lookup and state update into the result register
//  all ways of the selected set are compared in parallel
//  reset empties every set and clears the totals; costs return to 1 and 100
//  a stalled response holds the request register; cfg is always ready
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module set_assoc_lru_cache_lookup import sacl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sacl_req_if.sink    req,
    sacl_rsp_if.source  rsp,
    sacl_cfg_if.sink    cfg
);

    logic                    stg_valid_reg;
    logic                    stg_valid_next;
    logic [ADDR_IN_BITS-1:0] stg_addr_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    advance;
    logic                    stg_fire;
    logic                    req_fire;

    tag_row_t  tag_mem   [NUM_SETS];
    rank_row_t rank_reg  [NUM_SETS];
    fill_t     fill_reg  [NUM_SETS];

    cnt_t  hits_reg;
    cnt_t  hits_next;
    cnt_t  misses_reg;
    cnt_t  misses_next;
    cnt_t  lat_reg;
    cnt_t  lat_next;
    cost_t hit_cost_reg;
    cost_t miss_cost_reg;

    logic                    res_hit_reg;
    logic [WAY_OUT_BITS-1:0] res_way_reg;

    logic [ADDR_BITS-1:0] addr_used;
    set_t                 stg_set;
    tag_t                 stg_tag;
    lookup_t              lk;
    rank_row_t            ranks_next;
    fill_t                filled_next;

    assign advance   = !out_valid_reg || rsp.ready;
    assign stg_fire  = stg_valid_reg && advance;
    assign req.ready = !stg_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign addr_used = stg_addr_reg[ADDR_BITS-1:0];
    assign stg_set   = addr_used[SET_BITS-1:0];
    assign stg_tag   = addr_used[ADDR_BITS-1:SET_BITS];

    sacl_way_select u_way_select
    (
        .tags        (tag_mem[stg_set]),
        .ranks       (rank_reg[stg_set]),
        .filled      (fill_reg[stg_set]),
        .tag         (stg_tag),
        .lk          (lk),
        .ranks_next  (ranks_next),
        .filled_next (filled_next)
    );

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (req_fire)
            stg_valid_next = 1'b1;
        else if (stg_fire)
            stg_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (stg_fire)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;

        hits_next   = sat_add(hits_reg, lk.hit ? cnt_t'(1) : cnt_t'(0));
        misses_next = sat_add(misses_reg, lk.hit ? cnt_t'(0) : cnt_t'(1));
        lat_next    = sat_add(lat_reg, cnt_t'(lk.hit ? hit_cost_reg : miss_cost_reg));
    end

    // control and lookup state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            lat_reg       <= '0;
            hit_cost_reg  <= cost_t'(1);
            miss_cost_reg <= cost_t'(100);
            for (int s = 0; s < NUM_SETS; s++)
            begin
                rank_reg[s] <= '0;
                fill_reg[s] <= '0;
            end
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
            if (stg_fire)
            begin
                hits_reg          <= hits_next;
                misses_reg        <= misses_next;
                lat_reg           <= lat_next;
                rank_reg[stg_set] <= ranks_next;
                fill_reg[stg_set] <= filled_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_HIT_COST:  hit_cost_reg  <= cfg.data;
                    CFG_MISS_COST: miss_cost_reg <= cfg.data;
                    default:       ;
                endcase
            end
        end
    end

    // payload registers and tag store
    always_ff @(posedge clk)
    begin
        if (req_fire)
            stg_addr_reg <= req.address;
        if (stg_fire)
        begin
            res_hit_reg <= lk.hit;
            res_way_reg <= WAY_OUT_BITS'(lk.way);
            if (!lk.hit)
                tag_mem[stg_set][lk.way] <= stg_tag;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = res_hit_reg;
    assign rsp.way_used      = res_way_reg;
    assign rsp.hits_so_far   = hits_reg;
    assign rsp.misses_so_far = misses_reg;
    assign rsp.latency_total = lat_reg;

    // a hit leaves the miss total alone
    `ASSERT_NXT(a_hit_keeps_misses, clk, rst_n, stg_fire && lk.hit,
                misses_reg == $past(misses_reg))
    // a miss leaves its set non-empty
    `ASSERT_NXT(a_miss_fills_set, clk, rst_n, stg_fire && !lk.hit,
                fill_reg[$past(stg_set)] != '0)
    // a hit is only ever on a filled way
    `ASSERT_IMP(a_hit_way_filled, clk, rst_n, stg_fire && lk.hit,
                FILL_BITS'(lk.way) < fill_reg[stg_set])
    // back-pressure only when both registers are full and the sink stalls
    `ASSERT_IMP(a_ready_low_full, clk, rst_n, !req.ready,
                stg_valid_reg && out_valid_reg && !rsp.ready)

endmodule
